/* rtl/button_auto_repeat_core_macros.svh */
// Assertion helpers for the button auto-repeat block.
// Each expects clk and rst_n in scope.
`ifndef BUTTON_AUTO_REPEAT_CORE_MACROS_SVH
`define BUTTON_AUTO_REPEAT_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bar_pkg.sv */
package bar_pkg;

  localparam int unsigned TickW  = 48;
  localparam int unsigned MaskW  = 32;
  localparam int unsigned ThrW   = 8;
  localparam int unsigned CountW = ThrW + 1;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 48;

  localparam logic [TickW-1:0] SlowDelayRst = TickW'(250000);
  localparam logic [TickW-1:0] FastDelayRst = TickW'(100000);
  localparam logic [ThrW-1:0]  FastAfterRst = ThrW'(3);
  localparam logic [MaskW-1:0] RepeatMaskRst = '0;

  typedef enum logic [1:0] {
    EV_RELEASED = 2'd0,
    EV_PRESS    = 2'd1,
    EV_REPEAT   = 2'd2,
    EV_WAIT     = 2'd3
  } event_kind_t;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_SLOW_DELAY = 2'd0,
    CFG_FAST_DELAY = 2'd1,
    CFG_FAST_AFTER = 2'd2,
    CFG_RPT_MASK   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [TickW-1:0] now_tick;
    logic [MaskW-1:0] pressed_buttons;
  } in_t;

  typedef struct packed {
    logic [MaskW-1:0] reported_buttons;
    event_kind_t      event_kind;
  } out_t;

  typedef struct packed {
    logic [TickW-1:0] slow_delay;
    logic [TickW-1:0] fast_delay;
    logic [ThrW-1:0]  fast_after_count;
    logic [MaskW-1:0] repeat_mask;
  } cfg_t;

  typedef struct packed {
    logic [MaskW-1:0]  held_buttons;
    logic [TickW-1:0]  last_event_tick;
    logic [CountW-1:0] repeat_count;
  } rpt_state_t;

endpackage

/* rtl/bar_step.sv */
module bar_step (
  input  bar_pkg::in_t       req,
  input  bar_pkg::rpt_state_t st,
  input  bar_pkg::cfg_t      cfg,
  output bar_pkg::rpt_state_t st_nxt,
  output bar_pkg::out_t      res
);
  import bar_pkg::*;

  logic [CountW-1:0] thr_ext;
  logic [TickW-1:0]  delay;
  logic [TickW-1:0]  elapsed;

  assign thr_ext = {1'b0, cfg.fast_after_count};
  assign delay   = (st.repeat_count >= thr_ext) ? cfg.fast_delay : cfg.slow_delay;
  // wraps modulo 2^48
  assign elapsed = req.now_tick - st.last_event_tick;

  always_comb begin
    st_nxt = st;
    res.reported_buttons = '0;
    res.event_kind       = EV_WAIT;
    if (req.pressed_buttons == '0) begin
      st_nxt               = '0;
      res.event_kind       = EV_RELEASED;
    end else if (req.pressed_buttons != st.held_buttons) begin
      st_nxt.held_buttons    = req.pressed_buttons;
      st_nxt.last_event_tick = req.now_tick;
      st_nxt.repeat_count    = '0;
      res.reported_buttons   = req.pressed_buttons;
      res.event_kind         = EV_PRESS;
    end else if (elapsed > delay) begin
      st_nxt.last_event_tick = req.now_tick;
      // saturate one past the threshold
      if (st.repeat_count <= thr_ext) begin
        st_nxt.repeat_count = st.repeat_count + CountW'(1);
      end
      res.reported_buttons = req.pressed_buttons & cfg.repeat_mask;
      res.event_kind       = EV_REPEAT;
    end
  end

endmodule

/* rtl/button_auto_repeat_core.sv */
// Two-rate auto-repeat for a 32-bit button mask.
// Input channel (in_valid/in_ready/in_data): one poll request per item, carrying
// the time stamp and the sampled button mask. Output channel (out_valid/
// out_ready/out_data): exactly one result per poll, in poll order.
// From acceptance to out_valid the request is registered, then evaluated
// against the held state and the result registered. Throughput is one poll
// per cycle while the output is not stalled; the held state is read and
// updated in the evaluation stage, so back-to-back polls see each other's effect.
// Configuration (cfg_we/cfg_addr/cfg_wdata) writes one register per cycle:
// 0 slow delay, 1 fast delay, 2 slow repeats before fast rate, 3 repeat mask.
// Write it only while no poll is in flight.
// Reset (rst_n low, synchronous) loads default register values, clears the
// held mask, time stamp and repeat count, and empties both stages.
// When out_ready is low the result holds; the input stage still takes one more
// request, then in_ready drops until the output moves.
module button_auto_repeat_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bar_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bar_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [bar_pkg::CfgAddrW-1:0]     cfg_addr,
  input  logic [bar_pkg::CfgDataW-1:0]     cfg_wdata
);
  import bar_pkg::*;

  cfg_t       cfg_r;
  rpt_state_t st_r, st_nxt;
  in_t        req_r;
  logic       req_valid_r;
  out_t       res_nxt, out_r;
  logic       out_valid_r;
  logic       advance;

  assign advance   = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !req_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_delay       <= SlowDelayRst;
      cfg_r.fast_delay       <= FastDelayRst;
      cfg_r.fast_after_count <= FastAfterRst;
      cfg_r.repeat_mask      <= RepeatMaskRst;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_SLOW_DELAY: cfg_r.slow_delay       <= cfg_wdata[TickW-1:0];
        CFG_FAST_DELAY: cfg_r.fast_delay       <= cfg_wdata[TickW-1:0];
        CFG_FAST_AFTER: cfg_r.fast_after_count <= cfg_wdata[ThrW-1:0];
        CFG_RPT_MASK:   cfg_r.repeat_mask      <= cfg_wdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  bar_step u_step (
    .req    (req_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_ready) begin
        req_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: load on acceptance / advance only
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (advance) begin
      out_r <= res_nxt;
    end
  end

endmodule

/* rtl/bar_checker.sv */
`include "button_auto_repeat_core_macros.svh"

module bar_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input bar_pkg::out_t out_data
);
  import bar_pkg::*;

  `BAR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `BAR_ASSERT_NOW(a_release_zero, out_valid && out_data.event_kind == EV_RELEASED, out_data.reported_buttons == '0, "release reports buttons")
  `BAR_ASSERT_NOW(a_wait_zero, out_valid && out_data.event_kind == EV_WAIT, out_data.reported_buttons == '0, "waiting reports buttons")
  `BAR_ASSERT_NOW(a_press_nonzero, out_valid && out_data.event_kind == EV_PRESS, out_data.reported_buttons != '0, "press reports empty mask")

endmodule

bind button_auto_repeat_core bar_checker u_bar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
